// ----- hdl/pudcb_pkg.sv -----
// ----------------------------------------------------------------------------
// pudcb_pkg
// Shared widths and types for the PLC up/down counter bank.
// ----------------------------------------------------------------------------
package pudcb_pkg;

  localparam int NumSlots  = 4;
  localparam int CountW    = 15;
  localparam int LevelW    = NumSlots;
  localparam int CfgIndexW = 2;

  typedef logic [CountW-1:0] count_t;
  typedef logic [LevelW-1:0] level_t;

  // per-channel inputs for one scan
  typedef struct packed {
    logic up;
    logic down;
    logic prev_up;
    logic prev_down;
    logic clear;
    logic load;
  } chan_ctl_t;

  // per-channel outcome of one scan
  typedef struct packed {
    logic   up_reached;
    logic   down_reached;
    count_t count;
  } chan_res_t;

endpackage

// ----- hdl/pudcb_if.sv -----
// ----------------------------------------------------------------------------
// pudcb_in_if / pudcb_out_if
// Valid/ready channels for scan requests and scan results.
// ----------------------------------------------------------------------------
interface pudcb_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] count_up;
  logic [3:0] count_down;
  logic [3:0] clear;
  logic [3:0] load;

  modport source (output valid, count_up, count_down, clear, load, input ready);
  modport sink   (input valid, count_up, count_down, clear, load, output ready);
endinterface

interface pudcb_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  up_reached;
  logic [3:0]  down_reached;
  logic [14:0] count_ch0;
  logic [14:0] count_ch1;
  logic [14:0] count_ch2;
  logic [14:0] count_ch3;

  modport source (output valid, up_reached, down_reached, count_ch0, count_ch1,
                  count_ch2, count_ch3, input ready);
  modport sink   (input valid, up_reached, down_reached, count_ch0, count_ch1,
                  count_ch2, count_ch3, output ready);
endinterface

// ----- hdl/pudcb_channel.sv -----
// ----------------------------------------------------------------------------
// pudcb_channel
// One CTUD counter: holds its count and computes the next one for a scan.
// ----------------------------------------------------------------------------
module pudcb_channel (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  pudcb_pkg::count_t    preset,
  input  pudcb_pkg::chan_ctl_t ctl,
  output pudcb_pkg::chan_res_t res
);
  import pudcb_pkg::*;

  count_t count;
  count_t count_next;
  logic   up_edge;
  logic   down_edge;

  assign up_edge   = ctl.up & ~ctl.prev_up;
  assign down_edge = ctl.down & ~ctl.prev_down;

  always_comb begin
    count_next = count;
    if (ctl.clear) begin
      count_next = '0;
    end else if (ctl.load) begin
      count_next = preset;
    end else if (!(ctl.up && ctl.down)) begin
      // a blocked up edge still lets a down edge through
      if (up_edge && (count < preset)) begin
        count_next = count + count_t'(1);
      end else if (down_edge && (count != '0)) begin
        count_next = count - count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step) begin
      count <= count_next;
    end
  end

  assign res.count        = count_next;
  assign res.up_reached   = (count_next >= preset);
  assign res.down_reached = (count_next == '0);

endmodule

// ----- hdl/plc_up_down_counter_bank_core.sv -----
// ----------------------------------------------------------------------------
// plc_up_down_counter_bank_core
// A request taken on in is held in the input register; once the result
// register is free, each counter updates from the input register into the
// result register, whose contents are shown on out.
// Throughput: one request per cycle while out does not stall (out.ready).
// Reset (rst, synchronous): counts, presets and stored levels clear to zero.
// ----------------------------------------------------------------------------
module plc_up_down_counter_bank_core #(
  parameter int CHANNELS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  pudcb_in_if.sink                    in,
  pudcb_out_if.source                 out,
  input  logic                        cfg_wr_en,
  input  logic [pudcb_pkg::CfgIndexW-1:0] cfg_index,
  input  pudcb_pkg::count_t            cfg_data
);
  import pudcb_pkg::*;

  localparam level_t ChanMask = level_t'((1 << CHANNELS) - 1);

  count_t preset [NumSlots];

  // input register
  logic   req_valid;
  level_t req_up;
  level_t req_down;
  level_t req_clear;
  level_t req_load;

  level_t prev_up;
  level_t prev_down;

  // result register
  logic   res_valid;
  level_t res_up_reached;
  level_t res_down_reached;
  count_t res_count [NumSlots];

  logic      out_free;
  logic      step;
  chan_res_t chan_res [NumSlots];

  assign out_free = ~res_valid | out.ready;
  assign step     = req_valid & out_free;
  assign in.ready = ~req_valid | out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumSlots; i++) begin
        preset[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      preset[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in.ready) begin
      req_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      req_up    <= in.count_up & ChanMask;
      req_down  <= in.count_down & ChanMask;
      req_clear <= in.clear & ChanMask;
      req_load  <= in.load & ChanMask;
    end
  end

  // levels kept for edge detection on every scan
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_up   <= '0;
      prev_down <= '0;
    end else if (step) begin
      prev_up   <= req_up;
      prev_down <= req_down;
    end
  end

  for (genvar g = 0; g < NumSlots; g++) begin : g_chan
    if (g < CHANNELS) begin : g_on
      chan_ctl_t ctl;
      assign ctl = '{up: req_up[g], down: req_down[g], prev_up: prev_up[g],
                     prev_down: prev_down[g], clear: req_clear[g],
                     load: req_load[g]};
      pudcb_channel u_chan (
        .clk    (clk),
        .rst    (rst),
        .step   (step),
        .preset (preset[g]),
        .ctl    (ctl),
        .res    (chan_res[g])
      );
    end else begin : g_off
      assign chan_res[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < NumSlots; i++) begin
        res_up_reached[i]   <= chan_res[i].up_reached;
        res_down_reached[i] <= chan_res[i].down_reached;
        res_count[i]        <= chan_res[i].count;
      end
    end
  end

  assign out.valid        = res_valid;
  assign out.up_reached   = res_up_reached;
  assign out.down_reached = res_down_reached;
  assign out.count_ch0    = res_count[0];
  assign out.count_ch1    = res_count[1];
  assign out.count_ch2    = res_count[2];
  assign out.count_ch3    = res_count[3];

  a_req_held: assert property (@(posedge clk) disable iff (rst)
    req_valid && !out_free |=> req_valid)
    else $error("pending request dropped while result stalled");

  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    !in.ready |-> req_valid && res_valid)
    else $error("ready low without a full pipeline");

  a_levels_masked: assert property (@(posedge clk) disable iff (rst)
    ((prev_up | prev_down) & ~ChanMask) == '0)
    else $error("stored level on an unused channel");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_down_reached[0] == (res_count[0] == '0) || CHANNELS < 1)
    else $error("down_reached disagrees with count");

endmodule
